[hw/rtl/kss_pkg.sv]
// Shared types, constants and command/status structs for the k-sorted stream sorter.
package kss_pkg;

    localparam int HEAP_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int K_W        = 4;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CMP_W      = (IDX_W + 2 > K_W + 1) ? IDX_W + 2 : K_W + 1;
    localparam logic [K_W-1:0] K_RESET = K_W'(3);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_out;
    } t_out_item;

    // Datapath operations, one per cycle
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_LOAD,
        OP_PUT,
        OP_UP,
        OP_DOWN,
        OP_EMIT_TOP,
        OP_POP
    } t_op;

    // Heap RAM read address selection
    typedef enum logic [1:0] {
        RD_NONE,
        RD_PARENT,
        RD_CHILD,
        RD_ROOT
    } t_rd;

    typedef struct packed {
        t_op op;
        t_rd rd;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic leaf;
        logic up_stop;
        logic dn_stop;
        logic cnt_one;
        logic out_free;
        logic last;
    } t_sts;

endpackage

[hw/rtl/kss_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // Write one entry, read two (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

[hw/rtl/kss_dp.sv]
// Heap datapath: heap RAM, entry count, hole index, sifting value and output register.
module kss_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kss_pkg::t_cmd         i_cmd,
    output kss_pkg::t_sts         o_sts,
    input  kss_pkg::t_in_item     i_item,
    input  logic                  i_cfg_we,
    input  logic [kss_pkg::K_W-1:0] i_cfg_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output kss_pkg::t_out_item    o_item
);

    logic [kss_pkg::K_W-1:0]          r_window_k;
    logic [kss_pkg::CNT_W-1:0]        r_cnt;
    logic [kss_pkg::IDX_W-1:0]        r_idx;
    logic signed [kss_pkg::DATA_W-1:0] r_val;
    logic                             r_last;
    logic                             r_out_valid;
    kss_pkg::t_out_item               r_out;

    logic [kss_pkg::CMP_W-1:0]        cap;
    logic [kss_pkg::CMP_W-1:0]        cnt_c;
    logic [kss_pkg::CMP_W-1:0]        lc;
    logic [kss_pkg::CMP_W-1:0]        rc;
    logic [kss_pkg::IDX_W-1:0]        parent;
    logic [kss_pkg::IDX_W-1:0]        raddr0;
    logic [kss_pkg::IDX_W-1:0]        raddr1;
    logic [kss_pkg::IDX_W-1:0]        waddr;
    logic [kss_pkg::DATA_W-1:0]       wdata;
    logic                             we;
    logic [kss_pkg::DATA_W-1:0]       rd0;
    logic [kss_pkg::DATA_W-1:0]       rd1;
    logic                             r_live;
    logic                             l_less;
    logic                             r_less;
    logic signed [kss_pkg::DATA_W-1:0] l_min;
    logic                             out_free;

    // Capacity is window_k + 1, saturated to the heap depth
    always_comb begin
        cap = kss_pkg::CMP_W'(r_window_k) + kss_pkg::CMP_W'(1);
        if (cap > kss_pkg::CMP_W'(kss_pkg::HEAP_DEPTH)) begin
            cap = kss_pkg::CMP_W'(kss_pkg::HEAP_DEPTH);
        end
    end

    // Heap index arithmetic
    assign cnt_c  = kss_pkg::CMP_W'(r_cnt);
    assign lc     = kss_pkg::CMP_W'({r_idx, 1'b1});
    assign rc     = lc + kss_pkg::CMP_W'(1);
    assign parent = (r_idx - kss_pkg::IDX_W'(1)) >> 1;
    assign r_live = rc < cnt_c;

    // Pick the smaller of hole value and live children
    assign l_less = $signed(rd0) < r_val;
    assign l_min  = l_less ? $signed(rd0) : r_val;
    assign r_less = r_live && ($signed(rd1) < l_min);

    assign out_free = !r_out_valid || !i_stall;

    // Read address selection
    always_comb begin
        raddr0 = '0;
        raddr1 = '0;
        unique case (i_cmd.rd)
            kss_pkg::RD_NONE: begin
                raddr0 = '0;
            end
            kss_pkg::RD_PARENT: begin
                raddr0 = parent;
            end
            kss_pkg::RD_CHILD: begin
                raddr0 = lc[kss_pkg::IDX_W-1:0];
                raddr1 = rc[kss_pkg::IDX_W-1:0];
            end
            kss_pkg::RD_ROOT: begin
                raddr0 = '0;
                raddr1 = kss_pkg::IDX_W'(r_cnt - kss_pkg::CNT_W'(1));
            end
        endcase
    end

    // Write port: hole fill or move an entry into the hole
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_val;
        unique case (i_cmd.op)
            kss_pkg::OP_PUT: begin
                we = 1'b1;
            end
            kss_pkg::OP_UP: begin
                we    = 1'b1;
                wdata = rd0;
            end
            kss_pkg::OP_DOWN: begin
                we    = 1'b1;
                wdata = r_less ? rd1 : rd0;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    kss_ram #(
        .WIDTH (kss_pkg::DATA_W),
        .DEPTH (kss_pkg::HEAP_DEPTH)
    ) u_heap (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    // Control registers: window, count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_k  <= kss_pkg::K_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_k <= i_cfg_data;
            end
            if (i_cmd.op == kss_pkg::OP_INSERT) begin
                r_cnt <= r_cnt + kss_pkg::CNT_W'(1);
            end else if (i_cmd.op == kss_pkg::OP_POP) begin
                r_cnt <= r_cnt - kss_pkg::CNT_W'(1);
            end
            if (i_cmd.op == kss_pkg::OP_EMIT_TOP || i_cmd.op == kss_pkg::OP_POP) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hole index, sifting value, output transfer
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            kss_pkg::OP_INSERT: begin
                r_val  <= i_item.value;
                r_last <= i_item.last;
                r_idx  <= r_cnt[kss_pkg::IDX_W-1:0];
            end
            kss_pkg::OP_LOAD: begin
                r_val  <= i_item.value;
                r_last <= i_item.last;
            end
            kss_pkg::OP_UP: begin
                r_idx <= parent;
            end
            kss_pkg::OP_DOWN: begin
                r_idx <= r_less ? rc[kss_pkg::IDX_W-1:0] : lc[kss_pkg::IDX_W-1:0];
            end
            kss_pkg::OP_EMIT_TOP: begin
                r_out.value_res <= $signed(rd0);
                r_out.last_out  <= 1'b0;
                r_idx           <= '0;
            end
            kss_pkg::OP_POP: begin
                r_out.value_res <= $signed(rd0);
                r_out.last_out  <= (r_cnt == kss_pkg::CNT_W'(1));
                r_val           <= $signed(rd1);
                r_idx           <= '0;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Status to the controller
    always_comb begin
        o_sts.full     = cnt_c >= cap;
        o_sts.idx_zero = (r_idx == '0);
        o_sts.leaf     = lc >= cnt_c;
        o_sts.up_stop  = $signed(rd0) <= r_val;
        o_sts.dn_stop  = !l_less && !r_less;
        o_sts.cnt_one  = (r_cnt == kss_pkg::CNT_W'(1));
        o_sts.out_free = out_free;
        o_sts.last     = r_last;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

[hw/rtl/kss_ctrl.sv]
// Controller state machine sequencing insert, replace, sift and drain steps.
module kss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  kss_pkg::t_sts i_sts,
    output kss_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_TOP_EMIT,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DR_RD,
        ST_DR_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state done_state;

    // After the hole is filled, drain on a last item
    assign done_state = i_sts.last ? ST_DR_RD : ST_IDLE;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd.op = kss_pkg::OP_NOP;
        o_cmd.rd = kss_pkg::RD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_sts.full) begin
                        o_cmd.op = kss_pkg::OP_LOAD;
                        o_cmd.rd = kss_pkg::RD_ROOT;
                        n_state  = ST_TOP_EMIT;
                    end else begin
                        o_cmd.op = kss_pkg::OP_INSERT;
                        n_state  = ST_UP_RD;
                    end
                end
            end
            ST_UP_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.op = kss_pkg::OP_PUT;
                    n_state  = done_state;
                end else begin
                    o_cmd.rd = kss_pkg::RD_PARENT;
                    n_state  = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (i_sts.up_stop) begin
                    o_cmd.op = kss_pkg::OP_PUT;
                    n_state  = done_state;
                end else begin
                    o_cmd.op = kss_pkg::OP_UP;
                    n_state  = ST_UP_RD;
                end
            end
            ST_TOP_EMIT: begin
                o_cmd.rd = kss_pkg::RD_ROOT;
                if (i_sts.out_free) begin
                    o_cmd.op = kss_pkg::OP_EMIT_TOP;
                    n_state  = ST_DN_RD;
                end
            end
            ST_DN_RD: begin
                if (i_sts.leaf) begin
                    o_cmd.op = kss_pkg::OP_PUT;
                    n_state  = done_state;
                end else begin
                    o_cmd.rd = kss_pkg::RD_CHILD;
                    n_state  = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (i_sts.dn_stop) begin
                    o_cmd.op = kss_pkg::OP_PUT;
                    n_state  = done_state;
                end else begin
                    o_cmd.op = kss_pkg::OP_DOWN;
                    n_state  = ST_DN_RD;
                end
            end
            ST_DR_RD: begin
                o_cmd.rd = kss_pkg::RD_ROOT;
                n_state  = ST_DR_EMIT;
            end
            ST_DR_EMIT: begin
                o_cmd.rd = kss_pkg::RD_ROOT;
                if (i_sts.out_free) begin
                    o_cmd.op = kss_pkg::OP_POP;
                    n_state  = i_sts.cnt_one ? ST_IDLE : ST_DN_RD;
                end
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

[hw/rtl/k_sorted_stream_sorter_core.sv]
// Top level of the k-sorted stream sorter: controller plus heap datapath.
//
// Sorts a stream in which every value sits at most window_k places from its
// sorted position, using a min-heap of up to min(window_k + 1, 16) signed
// entries held in a dual-read RAM. Until the heap is full an input is inserted
// and sifted up with no result; once full, each input transfers out the current
// minimum and takes its place with a sift-down. An input marked last is handled
// the same way and then drains the heap in ascending order, the final result
// carrying last_out. Inputs are taken one at a time: no new input is taken until
// the insert, replace or drain and all of its sifting are done, and emitting a
// result waits while the output is stalled. Each heap level of a sift takes a
// read step and then a compare step on the heap RAM. The heap needs no clearing
// after reset: only live entries are ever used. A window_k write applies to the
// next input and discards no entries.
module k_sorted_stream_sorter_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  kss_pkg::t_in_item       i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output kss_pkg::t_out_item      o_item,
    input  logic                    i_cfg_we,
    input  logic [kss_pkg::K_W-1:0] i_cfg_data
);

    kss_pkg::t_cmd cmd;
    kss_pkg::t_sts sts;

    kss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kss_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

[hw/rtl/kss_checker.sv]
// Port-level assertions for the sorter core and their bind to the top level.
module kss_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input kss_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input kss_pkg::t_out_item o_item
);

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // One item at a time: the cycle after an input transfer is stalled
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while previous item in progress");

    // A stalled input holds until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_item))
        else $error("stalled input changed");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

endmodule

bind k_sorted_stream_sorter_core kss_checker u_kss_checker (.*);

[sim/tb_k_sorted_stream_sorter_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the k-sorted stream sorter core, with a heap mirror as predictor.
module tb_k_sorted_stream_sorter_core;

    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 22;

    logic                    i_clk     = 1'b0;
    logic                    i_rst_n   = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    dut_stall;
    kss_pkg::t_in_item       in_item   = '0;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    kss_pkg::t_out_item      res_item;
    logic                    cfg_we    = 1'b0;
    logic [kss_pkg::K_W-1:0] cfg_data  = '0;

    // Heap mirror: live entries, fill count and the window it was built with
    logic signed [kss_pkg::DATA_W-1:0] heap_mirror [kss_pkg::HEAP_DEPTH];
    int unsigned                       heap_fill  = 0;
    logic [kss_pkg::K_W-1:0]           window_k   = kss_pkg::K_RESET;
    kss_pkg::t_out_item                sorted_q[$];
    int                                errors     = 0;
    bit                                idle_on    = 1'b1;

    k_sorted_stream_sorter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_stall    (dut_stall),
        .i_item     (in_item),
        .o_valid    (res_valid),
        .i_stall    (res_stall),
        .o_item     (res_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Generate the 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random while idling is enabled
    always @(posedge i_clk) begin
        res_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    // Push the root down until both live children are no smaller
    function automatic void mirror_sift_down();
        int unsigned                       idx, lc, rc, m;
        logic signed [kss_pkg::DATA_W-1:0] tmp;
        bit                                done;
        idx  = 0;
        done = 1'b0;
        while (!done) begin
            lc = 2 * idx + 1;
            rc = lc + 1;
            m  = idx;
            if (lc < heap_fill && heap_mirror[lc] < heap_mirror[m]) m = lc;
            if (rc < heap_fill && heap_mirror[rc] < heap_mirror[m]) m = rc;
            if (m == idx) begin
                done = 1'b1;
            end else begin
                tmp              = heap_mirror[m];
                heap_mirror[m]   = heap_mirror[idx];
                heap_mirror[idx] = tmp;
                idx              = m;
            end
        end
    endfunction

    // Advance the heap mirror by one input and queue the sorted values it releases
    function automatic void predict_sorted(input kss_pkg::t_in_item it);
        int unsigned                       cap, idx, par;
        logic signed [kss_pkg::DATA_W-1:0] tmp;
        kss_pkg::t_out_item                res;
        bit                                done;
        cap = window_k + 1;
        if (cap > kss_pkg::HEAP_DEPTH) cap = kss_pkg::HEAP_DEPTH;
        if (heap_fill < cap) begin
            // Insert at the end and climb
            idx              = heap_fill;
            heap_mirror[idx] = it.value;
            heap_fill++;
            done = 1'b0;
            while (!done && idx > 0) begin
                par = (idx - 1) / 2;
                if (heap_mirror[par] <= heap_mirror[idx]) begin
                    done = 1'b1;
                end else begin
                    tmp              = heap_mirror[par];
                    heap_mirror[par] = heap_mirror[idx];
                    heap_mirror[idx] = tmp;
                    idx              = par;
                end
            end
        end else begin
            // Full: release the minimum, replace it and sink
            res.value_res = heap_mirror[0];
            res.last_out  = 1'b0;
            sorted_q.push_back(res);
            heap_mirror[0] = it.value;
            mirror_sift_down();
        end
        // Drain everything on the final value of a stream
        if (it.last) begin
            while (heap_fill > 0) begin
                res.value_res = heap_mirror[0];
                heap_fill--;
                res.last_out = (heap_fill == 0);
                if (heap_fill > 0) begin
                    heap_mirror[0] = heap_mirror[heap_fill];
                    mirror_sift_down();
                end
                sorted_q.push_back(res);
            end
        end
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(negedge i_clk) begin : check_result
        kss_pkg::t_out_item want;
        if (i_rst_n && res_valid && !res_stall) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value %0d last %0b",
                         $time, $signed(res_item.value_res), res_item.last_out);
                errors++;
            end else begin
                want = sorted_q.pop_front();
                if (res_item.value_res !== want.value_res) begin
                    $display("%0t: value_res mismatch: expected %0d, actual %0d",
                             $time, $signed(want.value_res), $signed(res_item.value_res));
                    errors++;
                end
                if (res_item.last_out !== want.last_out) begin
                    $display("%0t: last_out mismatch: expected %0b, actual %0b",
                             $time, want.last_out, res_item.last_out);
                    errors++;
                end
            end
        end
    end

    // Offer one value and hold it until the transfer happens
    task automatic send_item(input logic signed [kss_pkg::DATA_W-1:0] value, input logic last);
        kss_pkg::t_in_item it;
        bit                stalled;
        it.value = value;
        it.last  = last;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do begin
            @(negedge i_clk);
            stalled = dut_stall;
            @(posedge i_clk);
        end while (stalled);
        predict_sorted(it);
    endtask

    // Drop valid, wait out all predicted results, then let the heap settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the window register once the block is idle
    task automatic write_window(input logic [kss_pkg::K_W-1:0] k);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= k;
        @(posedge i_clk);
        window_k = k;
        cfg_we   <= 1'b0;
    endtask

    // Send n values: shaped streams are k-sorted for the current window, others are noise
    task automatic send_stream(input int n, input bit shaped, input bit close);
        logic signed [kss_pkg::DATA_W-1:0] vals[$];
        logic signed [kss_pkg::DATA_W-1:0] tmp;
        longint                            cur;
        int unsigned                       step_max;
        int                                i, blk, pick;
        cur      = $signed($urandom);
        step_max = $urandom_range(1) ? 3 : (1 << 26);
        for (i = 0; i < n; i++) begin
            if (shaped) begin
                vals.push_back(cur[kss_pkg::DATA_W-1:0]);
                cur += $urandom_range(step_max);
                if (cur > 64'sh7FFF_FFFF) cur = 64'sh7FFF_FFFF;
            end else begin
                vals.push_back($urandom);
            end
        end
        // Shuffle within blocks of window_k + 1 so no value moves more than window_k
        if (shaped) begin
            blk = window_k + 1;
            for (i = 0; i < n; i++) begin
                pick       = i - (i % blk) + $urandom_range(i % blk);
                tmp        = vals[i];
                vals[i]    = vals[pick];
                vals[pick] = tmp;
            end
        end
        for (i = 0; i < n; i++) send_item(vals[i], close && (i == n - 1));
    endtask

    // Mix of windows, stream lengths, noise and streams left open across window writes
    task automatic run_random_streams(input int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(3) == 0) write_window(kss_pkg::K_W'($urandom_range(15)));
            n = $urandom_range(1, 2 * window_k + 4);
            if (n > items - sent) n = items - sent;
            send_stream(n, $urandom_range(99) < 80, $urandom_range(99) < 85);
            sent += n;
        end
        // Close whatever stream is still open
        send_item($signed($urandom), 1'b1);
    endtask

    // Reset window, extremes of the value range and duplicates
    task automatic test_default_window();
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sd1,        1'b0);
        send_item(32'sd5,         1'b0);
        send_item(32'sd5,         1'b0);
        send_item(32'sd1,         1'b1);
    endtask

    // Single-value stream and a stream shorter than the widest window
    task automatic test_short_stream();
        write_window(4'd15);
        send_item(32'sd42, 1'b1);
        send_item(32'sd7,  1'b0);
        send_item(-32'sd9, 1'b0);
        send_item(32'sd3,  1'b1);
    endtask

    // Zero window: every value passes straight through the one-entry heap
    task automatic test_window_zero();
        write_window(4'd0);
        send_item(32'sd10, 1'b0);
        send_item(32'sd20, 1'b0);
        send_item(32'sd20, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b1);
    endtask

    // Shrink the window with a part-filled heap, then grow it again mid-stream
    task automatic test_window_change();
        write_window(4'd7);
        send_item(32'sd50, 1'b0);
        send_item(32'sd40, 1'b0);
        send_item(32'sd60, 1'b0);
        send_item(32'sd30, 1'b0);
        send_item(32'sd70, 1'b0);
        write_window(4'd1);
        send_item(32'sd35, 1'b0);
        send_item(32'sd80, 1'b0);
        send_item(32'sd45, 1'b0);
        write_window(4'd15);
        send_item(32'sd90, 1'b0);
        send_item(32'sd55, 1'b1);
    endtask

    // Random streams with idling on both sides
    task automatic test_random_streams();
        run_random_streams(50);
    endtask

    // Random streams with no idling at all
    task automatic test_back_to_back();
        wait_idle();
        idle_on = 1'b0;
        run_random_streams(20);
        wait_idle();
        idle_on = 1'b1;
    endtask

    // Run the tests in turn and report
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_window();
        test_short_stream();
        test_window_zero();
        test_window_change();
        test_random_streams();
        test_back_to_back();
        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
